>>> rtl/eht_pkg.sv
// Package for the extendible hash table: sizes, codes, sequencer states, helpers.
// No dependencies.
`timescale 1ns / 1ps
package eht_pkg;
  localparam int MaxGlobalDepth = 6;
  localparam int MaxBuckets     = 64;
  localparam int SlotsPerBucket = 8;
  localparam int KeyWidth       = 32;
  localparam int ValueWidth     = 32;
  localparam int DirSize        = 1 << MaxGlobalDepth;
  localparam int BktW           = 6;
  localparam int SlotW          = 3;
  localparam int SlotAddrW      = BktW + SlotW;

  localparam logic [1:0] ReqFind   = 2'd0;
  localparam logic [1:0] ReqInsert = 2'd1;
  localparam logic [1:0] ReqRemove = 2'd2;

  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DIR, S_LD, S_LDGET, S_SCAN, S_ACT, S_INS,
    S_DBL, S_SPLIT, S_LDW2, S_MOVE, S_REPT, S_OUT
  } state_e;

  // directory entry as read: entries never written point to bucket index mod 2
  function automatic logic [BktW-1:0] dir_eff(input logic [BktW-1:0] rd,
                                              input logic vld,
                                              input logic [BktW-1:0] idx);
    dir_eff = vld ? rd : {{(BktW-1){1'b0}}, idx[0]};
  endfunction
endpackage

>>> rtl/eht_if.sv
// Channel interfaces: request, response and configuration write.
// Depends on eht_pkg.
`timescale 1ns / 1ps
interface eht_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       req_type;
  logic [eht_pkg::KeyWidth-1:0]     key;
  logic [eht_pkg::ValueWidth-1:0]   new_value;
  modport source (output valid, req_type, key, new_value, input ready);
  modport sink   (input valid, req_type, key, new_value, output ready);
endinterface

interface eht_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [eht_pkg::ValueWidth-1:0]   found_value;
  logic [2:0]                       global_depth;
  logic [6:0]                       bucket_count;
  logic [2:0]                       key_local_depth;
  modport source (output valid, status, found_value, global_depth, bucket_count,
                  key_local_depth, input ready);
  modport sink   (input valid, status, found_value, global_depth, bucket_count,
                  key_local_depth, output ready);
endinterface

interface eht_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/extendible_hash_table.sv
// Extendible hash table top level: sequencer, state flops and RAM instances.
// Depends on eht_pkg, eht_if and eht_ram.
`timescale 1ns / 1ps
//  channel | dir | fields                                   | handshake
//  req_i   | in  | req_type, key, new_value                 | valid/ready
//  rsp_o   | out | status, found_value, global_depth,       | valid/ready
//          |     | bucket_count, key_local_depth            |
//  cfg_i   | in  | data = entries_per_bucket                | valid/ready (ready=1)
//
// One request at a time, ready only in idle. Find, remove, update: from acceptance to
// response the steps are dir read, depth read, bucket scan, act and output; an insert
// into a bucket with room adds one insert step. Each split adds a directory copy when
// the directory doubles, depth writes and slot moves, a directory repoint pass, and a
// re-read of the key's bucket and retry, all through single RAM ports.
// Reset is asynchronous; valid flops stand for the directory and depth reset values.
// A result waiting in the output register stalls only the final output step.
module extendible_hash_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  eht_req_if.sink          req_i,
  eht_rsp_if.source        rsp_o,
  eht_cfg_if.sink          cfg_i
);
  localparam int BW = eht_pkg::BktW;

  eht_pkg::state_e state_q, state_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [1:0]  req_q;
  logic [eht_pkg::KeyWidth-1:0]   key_q;
  logic [eht_pkg::ValueWidth-1:0] val_q, hval_q, hval_d;
  logic [BW-1:0] b_q, b_d, nb_q, nb_d;
  logic [2:0]  ld_q, ld_d;
  logic        hit_q, hit_d, fin_q, fin_d, scanned_q, scanned_d;
  logic [2:0]  hslot_q, hslot_d;
  logic [1:0]  status_q, status_d;
  logic [2:0]  cur_q, cur_d;
  logic [6:0]  bkt_q, bkt_d;
  logic [3:0]  cap_q;

  // valid flops for reset values and slot occupancy
  logic [eht_pkg::DirSize-1:0]    dir_vld_q, ld_vld_q;
  logic [eht_pkg::SlotsPerBucket-1:0] slot_vld_q [eht_pkg::MaxBuckets];

  // RAM ports
  logic          dir_we, ld_we, sl_we;
  logic [BW-1:0] dir_waddr, dir_raddr, dir_wdata, dir_rdata;
  logic [BW-1:0] ld_waddr, ld_raddr;
  logic [2:0]    ld_wdata, ld_rdata;
  logic [eht_pkg::SlotAddrW-1:0] sl_waddr, sl_raddr;
  logic [eht_pkg::KeyWidth-1:0]   sk_wdata, sk_rdata;
  logic [eht_pkg::ValueWidth-1:0] sv_wdata, sv_rdata;

  // slot valid update requests
  logic          vset_en, vclr_en, vzero_en;
  logic [BW-1:0] vset_row, vclr_row;
  logic [2:0]    vset_bit, vclr_bit;

  logic          out_load;

  eht_ram #(.Width(BW), .Depth(eht_pkg::DirSize)) u_dir (
    .clk_i, .we_i(dir_we), .waddr_i(dir_waddr), .wdata_i(dir_wdata),
    .raddr_i(dir_raddr), .rdata_o(dir_rdata));
  eht_ram #(.Width(3), .Depth(eht_pkg::MaxBuckets)) u_ld (
    .clk_i, .we_i(ld_we), .waddr_i(ld_waddr), .wdata_i(ld_wdata),
    .raddr_i(ld_raddr), .rdata_o(ld_rdata));
  eht_ram #(.Width(eht_pkg::KeyWidth), .Depth(eht_pkg::MaxBuckets*8)) u_keys (
    .clk_i, .we_i(sl_we), .waddr_i(sl_waddr), .wdata_i(sk_wdata),
    .raddr_i(sl_raddr), .rdata_o(sk_rdata));
  eht_ram #(.Width(eht_pkg::ValueWidth), .Depth(eht_pkg::MaxBuckets*8)) u_vals (
    .clk_i, .we_i(sl_we), .waddr_i(sl_waddr), .wdata_i(sv_wdata),
    .raddr_i(sl_raddr), .rdata_o(sv_rdata));

  // directory index of the key, directory size, effective capacity
  logic [BW-1:0] idx, mask, iprev;
  logic [6:0]    dsize;
  logic [3:0]    cap, cnt_vld;
  logic [2:0]    sprev, free_b, free_nb;
  logic [eht_pkg::SlotsPerBucket-1:0] vb, vnb;
  logic [2:0]    ld_new;

  always_comb begin
    mask   = ~(6'h3f << cur_q);
    idx    = key_q[BW-1:0] & mask;
    dsize  = 7'd1 << cur_q;
    iprev  = cnt_q[BW-1:0] - 6'd1;
    sprev  = cnt_q[2:0] - 3'd1;
    cap    = (cap_q == 4'd0) ? 4'd1 : ((cap_q > 4'd8) ? 4'd8 : cap_q);
    vb     = slot_vld_q[b_q];
    vnb    = slot_vld_q[nb_q];
    ld_new = ld_q + 3'd1;
    cnt_vld = '0;
    for (int s = 0; s < 8; s++) cnt_vld = cnt_vld + {3'd0, vb[s]};
    free_b = '0;
    for (int s = 7; s >= 0; s--) if (!vb[s]) free_b = 3'(s);
    free_nb = '0;
    for (int s = 7; s >= 0; s--) if (!vnb[s]) free_nb = 3'(s);
  end

  assign req_i.ready = (state_q == eht_pkg::S_IDLE);
  assign cfg_i.ready = 1'b1;

  always_comb begin
    state_d = state_q;  cnt_d = cnt_q;  b_d = b_q;  nb_d = nb_q;  ld_d = ld_q;
    hit_d = hit_q;  hslot_d = hslot_q;  hval_d = hval_q;  status_d = status_q;
    fin_d = fin_q;  scanned_d = scanned_q;  cur_d = cur_q;  bkt_d = bkt_q;
    dir_we = 1'b0;  dir_waddr = '0;  dir_wdata = '0;  dir_raddr = idx;
    ld_we = 1'b0;  ld_waddr = b_q;  ld_wdata = ld_new;  ld_raddr = b_q;
    sl_we = 1'b0;  sl_waddr = {b_q, free_b};  sl_raddr = {b_q, cnt_q[2:0]};
    sk_wdata = key_q;  sv_wdata = val_q;
    vset_en = 1'b0;  vset_row = b_q;  vset_bit = free_b;
    vclr_en = 1'b0;  vclr_row = b_q;  vclr_bit = hslot_q;
    vzero_en = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      eht_pkg::S_IDLE: begin
        if (req_i.valid) begin
          state_d = eht_pkg::S_DIR;  fin_d = 1'b0;  scanned_d = 1'b0;
          hit_d = 1'b0;  hval_d = '0;  status_d = eht_pkg::StNotFound;
        end
      end
      eht_pkg::S_DIR: state_d = eht_pkg::S_LD;
      eht_pkg::S_LD: begin
        b_d = eht_pkg::dir_eff(dir_rdata, dir_vld_q[idx], idx);
        ld_raddr = b_d;
        state_d = eht_pkg::S_LDGET;
      end
      eht_pkg::S_LDGET: begin
        ld_d = ld_vld_q[b_q] ? ld_rdata : 3'd1;
        cnt_d = '0;
        if (fin_q) state_d = eht_pkg::S_OUT;
        else if (scanned_q) state_d = eht_pkg::S_INS;
        else state_d = eht_pkg::S_SCAN;
      end
      eht_pkg::S_SCAN: begin
        // read slot cnt, compare slot cnt-1
        if (cnt_q != 7'd0 && vb[sprev] && sk_rdata == key_q && !hit_q) begin
          hit_d = 1'b1;  hslot_d = sprev;  hval_d = sv_rdata;
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd8) begin
          state_d = eht_pkg::S_ACT;  scanned_d = 1'b1;
        end
      end
      eht_pkg::S_ACT: begin
        fin_d = 1'b1;
        state_d = eht_pkg::S_OUT;
        unique case (req_q)
          eht_pkg::ReqInsert: begin
            hval_d = '0;
            if (hit_q) begin
              sl_we = 1'b1;  sl_waddr = {b_q, hslot_q};  status_d = eht_pkg::StDone;
            end else begin
              fin_d = 1'b0;  state_d = eht_pkg::S_INS;
            end
          end
          eht_pkg::ReqRemove: begin
            hval_d = '0;
            if (hit_q) begin
              vclr_en = 1'b1;  status_d = eht_pkg::StDone;
            end
          end
          default: if (hit_q) status_d = eht_pkg::StDone;
        endcase
      end
      eht_pkg::S_INS: begin
        fin_d = 1'b1;
        state_d = eht_pkg::S_OUT;
        if (cnt_vld < cap) begin
          sl_we = 1'b1;  vset_en = 1'b1;  status_d = eht_pkg::StDone;
        end else if (bkt_q >= 7'(eht_pkg::MaxBuckets)) begin
          status_d = eht_pkg::StFull;
        end else if (ld_q >= cur_q) begin
          if (cur_q >= 3'(eht_pkg::MaxGlobalDepth)) status_d = eht_pkg::StFull;
          else begin
            fin_d = 1'b0;  cnt_d = '0;  state_d = eht_pkg::S_DBL;
          end
        end else begin
          fin_d = 1'b0;  state_d = eht_pkg::S_SPLIT;
        end
      end
      eht_pkg::S_DBL: begin
        // copy the lower directory half into the upper half
        dir_raddr = cnt_q[BW-1:0];
        if (cnt_q != 7'd0) begin
          dir_we = 1'b1;
          dir_waddr = iprev + dsize[BW-1:0];
          dir_wdata = eht_pkg::dir_eff(dir_rdata, dir_vld_q[iprev], iprev);
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == dsize) begin
          cur_d = cur_q + 3'd1;  state_d = eht_pkg::S_SPLIT;
        end
      end
      eht_pkg::S_SPLIT: begin
        nb_d = bkt_q[BW-1:0];
        bkt_d = bkt_q + 7'd1;
        ld_we = 1'b1;
        vzero_en = 1'b1;
        state_d = eht_pkg::S_LDW2;
      end
      eht_pkg::S_LDW2: begin
        ld_we = 1'b1;  ld_waddr = nb_q;
        cnt_d = '0;
        state_d = eht_pkg::S_MOVE;
      end
      eht_pkg::S_MOVE: begin
        // pairs whose next key bit is set go to the new bucket
        if (cnt_q != 7'd0 && vb[sprev] && sk_rdata[ld_q]) begin
          sl_we = 1'b1;  sl_waddr = {nb_q, free_nb};  sk_wdata = sk_rdata;
          sv_wdata = sv_rdata;
          vset_en = 1'b1;  vset_row = nb_q;  vset_bit = free_nb;
          vclr_en = 1'b1;  vclr_bit = sprev;
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd8) begin
          cnt_d = '0;  state_d = eht_pkg::S_REPT;
        end
      end
      eht_pkg::S_REPT: begin
        dir_raddr = cnt_q[BW-1:0];
        if (cnt_q != 7'd0 && iprev[ld_q] &&
            eht_pkg::dir_eff(dir_rdata, dir_vld_q[iprev], iprev) == b_q) begin
          dir_we = 1'b1;  dir_waddr = iprev;  dir_wdata = nb_q;
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == dsize) state_d = eht_pkg::S_DIR;
      end
      eht_pkg::S_OUT: begin
        if (!rsp_o.valid || rsp_o.ready) begin
          out_load = 1'b1;  state_d = eht_pkg::S_IDLE;
        end
      end
      default: state_d = eht_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= eht_pkg::S_IDLE;
      cur_q <= 3'd1;
      bkt_q <= 7'd2;
      cap_q <= 4'd4;
      dir_vld_q <= '0;
      ld_vld_q <= '0;
      for (int i = 0; i < eht_pkg::MaxBuckets; i++) slot_vld_q[i] <= '0;
      rsp_o.valid <= 1'b0;
      fin_q <= 1'b0;
      scanned_q <= 1'b0;
      hit_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;  cur_q <= cur_d;  bkt_q <= bkt_d;
      fin_q <= fin_d;  scanned_q <= scanned_d;  hit_q <= hit_d;  cnt_q <= cnt_d;
      if (cfg_i.valid) cap_q <= cfg_i.data;
      if (dir_we) dir_vld_q[dir_waddr] <= 1'b1;
      if (ld_we) ld_vld_q[ld_waddr] <= 1'b1;
      if (vzero_en) slot_vld_q[nb_d] <= '0;
      if (vclr_en) slot_vld_q[vclr_row][vclr_bit] <= 1'b0;
      if (vset_en) slot_vld_q[vset_row][vset_bit] <= 1'b1;
      if (out_load) rsp_o.valid <= 1'b1;
      else if (rsp_o.ready) rsp_o.valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == eht_pkg::S_IDLE && req_i.valid) begin
      req_q <= req_i.req_type;  key_q <= req_i.key;  val_q <= req_i.new_value;
    end
    b_q <= b_d;  nb_q <= nb_d;  ld_q <= ld_d;  hslot_q <= hslot_d;
    hval_q <= hval_d;  status_q <= status_d;
    if (out_load) begin
      rsp_o.status          <= status_q;
      rsp_o.found_value     <= hval_q;
      rsp_o.global_depth    <= cur_q;
      rsp_o.bucket_count    <= bkt_q;
      rsp_o.key_local_depth <= ld_q;
    end
  end
endmodule

>>> rtl/eht_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module eht_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
